FILE: rtl/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg: shared types and constants for the sorted table
// Holds the table size, field widths, request codes and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sti_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int VAL_W       = 32;
	localparam int POS_W       = 4;
	localparam int CNT_OUT_W   = 5;

	// Request codes carried on the mode field
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic insert;
		logic remove;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic full;
		logic pos_valid;
	} status_t;

endpackage

FILE: rtl/sti_ctrl.sv
// ----------------------------------------------------------------------------
// sti_ctrl: request controller
// Accepts one request, checks it against the datapath status, issues the
// table update and holds the result until the output side takes it.
// ----------------------------------------------------------------------------
module sti_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              accepted,
	input  sti_pkg::status_t  status,
	output sti_pkg::cmd_t     cmd
);

	localparam logic ST_EMPTY = 1'b0;
	localparam logic ST_HOLD  = 1'b1;

	logic state_q;
	logic state_next;
	logic accepted_q;
	logic take;

	// Stall the input only while a result waits and the output is stalled
	assign in_stall = (state_q == ST_HOLD) && out_stall;
	assign take     = in_valid && !in_stall;

	// Decide whether the request is carried out
	always_comb begin
		cmd.insert = 1'b0;
		cmd.remove = 1'b0;
		if (take) begin
			if (mode == sti_pkg::MODE_INSERT) begin
				cmd.insert = !status.full;
			end else begin
				cmd.remove = status.pos_valid;
			end
		end
	end

	// Advance the result register state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_EMPTY: begin
				if (take) state_next = ST_HOLD;
			end
			ST_HOLD: begin
				if (take) state_next = ST_HOLD;
				else if (!out_stall) state_next = ST_EMPTY;
			end
			default: state_next = ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_next;
		end
	end

	// Capture the outcome flag with each request
	always_ff @(posedge clk) begin
		if (take) begin
			accepted_q <= cmd.insert || cmd.remove;
		end
	end

	assign out_valid = (state_q == ST_HOLD);
	assign accepted  = accepted_q;

endmodule

FILE: rtl/sti_datapath.sv
// ----------------------------------------------------------------------------
// sti_datapath: row of compare-and-shift cells
// Each cell compares the incoming value with its own entry and picks its
// next content from itself, its lower neighbor, its upper neighbor or the
// new value, so an insert or remove updates every cell together.
// ----------------------------------------------------------------------------
module sti_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sti_pkg::cmd_t                  cmd,
	input  logic signed [sti_pkg::VAL_W-1:0] value,
	input  logic [sti_pkg::POS_W-1:0]      position,
	output sti_pkg::status_t               status,
	output logic [sti_pkg::CNT_W-1:0]      count
);

	logic signed [sti_pkg::VAL_W-1:0] cells_q [sti_pkg::TABLE_DEPTH];
	logic signed [sti_pkg::VAL_W-1:0] cells_next [sti_pkg::TABLE_DEPTH];
	logic [sti_pkg::TABLE_DEPTH-1:0]  above;
	logic [sti_pkg::CNT_W-1:0]        count_q;

	// Mark valid cells that hold an entry larger than the new value
	always_comb begin
		for (int i = 0; i < sti_pkg::TABLE_DEPTH; i++) begin
			above[i] = (i < int'(count_q)) && (value < cells_q[i]);
		end
	end

	// Pick each cell's next content
	always_comb begin
		for (int i = 0; i < sti_pkg::TABLE_DEPTH; i++) begin
			cells_next[i] = cells_q[i];
			if (cmd.insert) begin
				if (i > 0 && above[(i > 0) ? i - 1 : 0]) begin
					cells_next[i] = cells_q[(i > 0) ? i - 1 : 0];
				end else if (above[i] || i == int'(count_q)) begin
					cells_next[i] = value;
				end
			end else if (cmd.remove) begin
				if (i >= int'(position) && i < sti_pkg::TABLE_DEPTH - 1) begin
					cells_next[i] = cells_q[(i < sti_pkg::TABLE_DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	// Hold entries unless a command moves them
	always_ff @(posedge clk) begin
		if (cmd.insert || cmd.remove) begin
			for (int i = 0; i < sti_pkg::TABLE_DEPTH; i++) begin
				cells_q[i] <= cells_next[i];
			end
		end
	end

	// Track the entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.insert) begin
			count_q <= count_q + sti_pkg::CNT_W'(1);
		end else if (cmd.remove) begin
			count_q <= count_q - sti_pkg::CNT_W'(1);
		end
	end

	assign status.full      = (int'(count_q) >= sti_pkg::TABLE_DEPTH);
	assign status.pos_valid = (int'(position) < int'(count_q));
	assign count            = count_q;

endmodule

FILE: rtl/sorted_table_insert_remove.sv
// Result: the outcome of an accepted request is registered and valid in the next cycle.
// Throughput: one request per cycle unless a held result is stalled at the output;
// the compare-and-shift cell row finishes any insert or remove in one table update,
// and the result register lets the next request in while a result is being taken.
// Reset: arst_n clears the entry count and the result valid; table entries are not
// cleared, and only entries below the count are ever read.
// ----------------------------------------------------------------------------
// sorted_table_insert_remove: bounded sorted table with insert and remove
// Keeps signed values in ascending order; inserts at the sorted place and
// removes by index, reporting the outcome and the entry count.
// ----------------------------------------------------------------------------
module sorted_table_insert_remove (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             mode,
	input  logic signed [sti_pkg::VAL_W-1:0] value,
	input  logic [sti_pkg::POS_W-1:0]        position,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             accepted,
	output logic [sti_pkg::CNT_OUT_W-1:0]    entry_count
);

	sti_pkg::cmd_t             cmd;
	sti_pkg::status_t          status;
	logic [sti_pkg::CNT_W-1:0] count;

	sti_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.accepted  (accepted),
		.status    (status),
		.cmd       (cmd)
	);

	sti_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.value    (value),
		.position (position),
		.status   (status),
		.count    (count)
	);

	// Count only changes on the next request, so it stays with the held result
	assign entry_count = sti_pkg::CNT_OUT_W'(count);

endmodule

FILE: rtl/sti_checker.sv
// ----------------------------------------------------------------------------
// sti_checker: port-level checks for the sorted table
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module sti_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic                             accepted,
	input logic [sti_pkg::CNT_OUT_W-1:0]    entry_count
);

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(accepted) && $stable(entry_count))
		else $error("stalled result changed");

	// Every request yields a result in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("request produced no result");

	// A taken result with no new request leaves the output empty
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !(in_valid && !in_stall) |=> !out_valid)
		else $error("result repeated");

	// The input is only stalled while a result is waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with no pending result");

endmodule

bind sorted_table_insert_remove sti_checker u_sti_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.accepted    (accepted),
	.entry_count (entry_count)
);

FILE: verif/sorted_table_insert_remove_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_table_insert_remove_check: result checker for the sorted table
// Watches both channels, keeps its own sorted table and entry count, predicts
// the outcome of every accepted request and compares it, in order, with the
// results the block delivers. Mismatch and progress counts go to the top.
// ----------------------------------------------------------------------------
module sorted_table_insert_remove_check (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              mode,
	input  logic signed [sti_pkg::VAL_W-1:0]  value,
	input  logic [sti_pkg::POS_W-1:0]         position,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic                              accepted,
	input  logic [sti_pkg::CNT_OUT_W-1:0]     entry_count,
	output int                                mismatches,
	output int                                pending_results,
	output int                                results_checked,
	output int                                refused
);

	typedef struct packed {
		logic                          done;
		logic [sti_pkg::CNT_OUT_W-1:0] entries;
	} outcome_t;

	// Shadow copy of the table; only entries below shadow_count are ever read
	logic signed [sti_pkg::VAL_W-1:0] shadow_vals [sti_pkg::TABLE_DEPTH];
	int unsigned                      shadow_count;

	outcome_t pending_outcomes [$];
	outcome_t oldest;
	outcome_t predicted;
	int       mismatch_total;
	int       checked_total;
	int       refused_total;

	// Apply one request to the shadow table and return the outcome it yields
	function automatic outcome_t insert_or_remove(input logic m,
			input logic signed [sti_pkg::VAL_W-1:0] v, input logic [sti_pkg::POS_W-1:0] p);
		outcome_t    o;
		int unsigned slot;
		int unsigned i;
		o.done = 1'b0;
		if (m == sti_pkg::MODE_INSERT) begin
			if (shadow_count < sti_pkg::TABLE_DEPTH) begin
				// shift larger entries up until the slot for v opens
				slot = shadow_count;
				while (slot > 0 && v < shadow_vals[slot - 1]) begin
					shadow_vals[slot] = shadow_vals[slot - 1];
					slot--;
				end
				shadow_vals[slot] = v;
				shadow_count++;
				o.done = 1'b1;
			end
		end else if (p < shadow_count) begin
			// close the gap left by the removed entry
			for (i = p; i + 1 < shadow_count; i++)
				shadow_vals[i] = shadow_vals[i + 1];
			shadow_count--;
			o.done = 1'b1;
		end
		o.entries = sti_pkg::CNT_OUT_W'(shadow_count);
		return o;
	endfunction

	// Compare results first, then record the new request, so a result taken
	// at the same edge is matched against what was already expected
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_count = 0;
			pending_outcomes.delete();
			mismatch_total = 0;
			checked_total = 0;
			refused_total = 0;
			mismatches <= 0;
			pending_results <= 0;
			results_checked <= 0;
			refused <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_outcomes.size() == 0) begin
					mismatch_total++;
					if (mismatch_total <= 10)
						$display("%0t: unexpected result: accepted=%0b count=%0d",
							$realtime, accepted, entry_count);
				end else begin
					oldest = pending_outcomes.pop_front();
					checked_total++;
					if (accepted !== oldest.done || entry_count !== oldest.entries) begin
						mismatch_total++;
						if (mismatch_total <= 10)
							$display("%0t: expected acc=%0b cnt=%0d, got acc=%0b cnt=%0d",
								$realtime, oldest.done, oldest.entries,
								accepted, entry_count);
					end
				end
			end
			if (in_valid && !in_stall) begin
				predicted = insert_or_remove(mode, value, position);
				if (!predicted.done)
					refused_total++;
				pending_outcomes.push_back(predicted);
			end
			// publish counts after the edge so the top never races them
			mismatches <= mismatch_total;
			pending_results <= pending_outcomes.size();
			results_checked <= checked_total;
			refused <= refused_total;
		end
	end

endmodule

FILE: verif/sorted_table_insert_remove_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_table_insert_remove_test: testbench top for the sorted table
// Drives directed corner requests and then long random insert/remove runs
// with random idling on both sides, a long receiver hold-off and drain
// pauses; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sorted_table_insert_remove_test;

	localparam int QUIET_LIMIT = 1000;
	localparam int HOLD_CYCLES = 80;
	localparam logic signed [sti_pkg::VAL_W-1:0] VAL_MAX =
		{1'b0, {(sti_pkg::VAL_W - 1){1'b1}}};
	localparam logic signed [sti_pkg::VAL_W-1:0] VAL_MIN =
		{1'b1, {(sti_pkg::VAL_W - 1){1'b0}}};

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 in_valid;
	logic                                 in_stall;
	logic                                 mode;
	logic signed [sti_pkg::VAL_W-1:0]     value;
	logic [sti_pkg::POS_W-1:0]            position;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	logic                                 accepted;
	logic [sti_pkg::CNT_OUT_W-1:0]        entry_count;

	int   mismatches;
	int   pending_results;
	int   results_checked;
	int   refused;
	int   requests_sent = 0;
	int   quiet_cycles = 0;
	int   hold_request = 0;
	int   hold_served = 0;
	int   hold_left = 0;
	logic no_idle = 1'b0;

	sorted_table_insert_remove DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.value       (value),
		.position    (position),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.accepted    (accepted),
		.entry_count (entry_count)
	);

	sorted_table_insert_remove_check table_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.mode            (mode),
		.value           (value),
		.position        (position),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.accepted        (accepted),
		.entry_count     (entry_count),
		.mismatches      (mismatches),
		.pending_results (pending_results),
		.results_checked (results_checked),
		.refused         (refused)
	);

	// Generate clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall results at random; hold off for a long stretch when asked
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_request != hold_served) begin
			hold_served <= hold_request;
			hold_left <= HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !no_idle && ($urandom_range(99) < 9);
		end
	end

	// Abort when neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: nothing moved for %0d cycles", $realtime, QUIET_LIMIT);
			$display("sorted_table_insert_remove_test: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one request, maybe after idling first, and hold it until taken
	task automatic issue(input logic m, input logic signed [sti_pkg::VAL_W-1:0] v,
			input logic [sti_pkg::POS_W-1:0] p);
		if (!no_idle && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		value <= v;
		position <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		requests_sent++;
	endtask

	// Stop offering and wait for every outstanding result
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
	endtask

	// Random requests; the insert share swings every 40 requests so the
	// table keeps filling up and emptying out
	task automatic random_burst(input int n);
		logic                             m;
		logic signed [sti_pkg::VAL_W-1:0] v;
		logic [sti_pkg::POS_W-1:0]        p;
		int                               insert_pct;
		repeat (n) begin
			insert_pct = ((requests_sent / 40) % 2 == 0) ? 70 : 30;
			m = ($urandom_range(99) < insert_pct) ? sti_pkg::MODE_INSERT
				: sti_pkg::MODE_REMOVE;
			case ($urandom_range(3))
				0, 1: v = $urandom;
				2: v = sti_pkg::VAL_W'(int'($urandom_range(8)) - 4);
				default: begin
					case ($urandom_range(3))
						0: v = VAL_MAX;
						1: v = VAL_MIN;
						2: v = '0;
						default: v = '1;
					endcase
				end
			endcase
			p = $urandom_range(1) ? sti_pkg::POS_W'($urandom_range(3))
				: sti_pkg::POS_W'($urandom_range(15));
			issue(m, v, p);
		end
	endtask

	initial begin
		in_valid <= 1'b0;
		mode <= sti_pkg::MODE_INSERT;
		value <= '0;
		position <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// remove from an empty table, at both ends of the index range
		issue(sti_pkg::MODE_REMOVE, '0, 4'd0);
		issue(sti_pkg::MODE_REMOVE, '1, 4'd15);
		// extremes and a duplicate
		issue(sti_pkg::MODE_INSERT, VAL_MAX, '0);
		issue(sti_pkg::MODE_INSERT, VAL_MIN, '1);
		issue(sti_pkg::MODE_INSERT, '0, '0);
		issue(sti_pkg::MODE_INSERT, '1, '0);
		issue(sti_pkg::MODE_INSERT, 32'sd1, '0);
		issue(sti_pkg::MODE_INSERT, '0, '0);
		// remove the head, then at the count, then the tail
		issue(sti_pkg::MODE_REMOVE, '0, 4'd0);
		issue(sti_pkg::MODE_REMOVE, '0, 4'd5);
		issue(sti_pkg::MODE_REMOVE, '0, 4'd4);
		// fill the table, insert into it while full, remove the last slot
		for (int i = 0; i < 12; i++)
			issue(sti_pkg::MODE_INSERT, sti_pkg::VAL_W'(i * 1000 - 6000), '0);
		issue(sti_pkg::MODE_INSERT, 32'sd7, '0);
		issue(sti_pkg::MODE_REMOVE, '0, 4'd15);

		random_burst(300);

		// long receiver hold-off while requests keep coming
		hold_request <= hold_request + 1;
		random_burst(40);
		wait_drained();

		// back-to-back stretch with no idling on either side
		no_idle <= 1'b1;
		random_burst(200);
		no_idle <= 1'b0;
		random_burst(460);
		wait_drained();
		repeat (4) @(posedge clk);

		$display("Ran %0d requests: directed corners, random insert/remove, long hold-off,",
			requests_sent);
		$display("drain pauses, no-idle stretch; %0d results checked, %0d refused.",
			results_checked, refused);
		if (mismatches == 0 && pending_results == 0)
			$display("sorted_table_insert_remove_test: PASS");
		else
			$display("sorted_table_insert_remove_test: FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/sti_pkg.sv
rtl/sti_ctrl.sv
rtl/sti_datapath.sv
rtl/sorted_table_insert_remove.sv
rtl/sti_checker.sv
verif/sorted_table_insert_remove_check.sv
verif/sorted_table_insert_remove_test.sv
